// ===== rtl/sync_framed_pixel_receiver_defines.svh =====
// Assertion macros shared by the sync-framed pixel receiver RTL.
// Depends on nothing; each user module must have ports named clock and reset.
`ifndef SYNC_FRAMED_PIXEL_RECEIVER_DEFINES_SVH
`define SYNC_FRAMED_PIXEL_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SFPR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFPR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sfpr_pkg.sv =====
// Package for the sync-framed pixel receiver: opcodes, event and phase codes,
// register indexes and the structs passed between the submodules. No dependencies.
`default_nettype none

package sfpr_pkg;

   // Item opcodes.
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Result events.
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_GOOD     = 2'd1;
   localparam logic [1:0] EV_CHECKSUM = 2'd2;
   localparam logic [1:0] EV_TIMEOUT  = 2'd3;

   // Receiver phases.
   localparam logic [1:0] PH_SYNC1 = 2'd0;
   localparam logic [1:0] PH_SYNC2 = 2'd1;
   localparam logic [1:0] PH_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_LED_COUNT = 2'd0;
   localparam logic [1:0] REG_TIMEOUT   = 2'd1;
   localparam logic [1:0] REG_SYNC1     = 2'd2;
   localparam logic [1:0] REG_SYNC2     = 2'd3;

   // Reset values of the registers.
   localparam logic [9:0]  RST_LED_COUNT = 10'd300;
   localparam logic [15:0] RST_TIMEOUT   = 16'd50;
   localparam logic [7:0]  RST_SYNC1     = 8'hFF;
   localparam logic [7:0]  RST_SYNC2     = 8'hAA;

   // Colour byte lane of the last byte of a pixel.
   localparam logic [1:0] LANE_LAST = 2'd2;

   // Per-item bookkeeping computed at acceptance.
   typedef struct packed {
      logic [1:0]  event_res;
      logic [31:0] good_frames;
      logic [31:0] dropped_frames;
      logic [1:0]  receiver_phase;
      logic        pixel_hit;
   } meta_type;

   // One finished result item.
   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [31:0] good_frames;
      logic [31:0] dropped_frames;
      logic [1:0]  receiver_phase;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/sfpr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sfpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                    wr_data,
   input  wire logic                                rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sfpr_ctrl.sv =====
// Frame receive control: configuration registers, sync/phase tracking,
// checksum, timeout, bank select and counters. Uses sfpr_pkg and the defines header.
`default_nettype none
`include "sync_framed_pixel_receiver_defines.svh"

module sfpr_ctrl #(
   parameter int MAX_LEDS = 512
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_wdata,
   input  wire logic                 item_accept,
   input  wire logic [1:0]           opcode,
   input  wire logic [7:0]           rx_byte,
   input  wire logic [8:0]           pixel_index,
   output logic      [2:0]           ram_wr_lane,
   output logic [(MAX_LEDS > 1 ? $clog2(MAX_LEDS) : 1):0] ram_wr_addr,
   output logic      [7:0]           ram_wr_data,
   output logic                      ram_rd_en,
   output logic [(MAX_LEDS > 1 ? $clog2(MAX_LEDS) : 1):0] ram_rd_addr,
   output sfpr_pkg::meta_type        meta
);

   localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int LED_W = $clog2(MAX_LEDS + 1);
   localparam int CMP_W = (LED_W > 10) ? LED_W : 10;

   logic [9:0]  led_count_ff;
   logic [15:0] timeout_ff;
   logic [7:0]  sync1_ff;
   logic [7:0]  sync2_ff;

   logic [1:0]       phase_ff, phase_in;
   logic [LED_W-1:0] led_ff, led_in;
   logic [1:0]       lane_ff, lane_in;
   logic [7:0]       parity_ff, parity_in;
   logic [15:0]      ticks_ff, ticks_in;
   logic             bank_ff, bank_in;
   logic             have_ff, have_in;
   logic [31:0]      good_ff, good_in;
   logic [31:0]      drop_ff, drop_in;

   logic [CMP_W-1:0] eff_leds;
   logic [CMP_W-1:0] led_wide;
   logic [CMP_W-1:0] pix_wide;
   logic [31:0]      good_inc;
   logic [31:0]      drop_inc;
   logic [15:0]      ticks_inc;
   logic [1:0]       event_res;
   logic             pixel_hit;

   // Effective LED count: zero acts as one, anything above the store acts as full.
   always_comb begin
      if (led_count_ff == 10'd0) begin
         eff_leds = CMP_W'(1);
      end else if (CMP_W'(led_count_ff) > CMP_W'(MAX_LEDS)) begin
         eff_leds = CMP_W'(MAX_LEDS);
      end else begin
         eff_leds = CMP_W'(led_count_ff);
      end
   end

   assign led_wide  = CMP_W'(led_ff);
   assign pix_wide  = CMP_W'(pixel_index);
   assign good_inc  = (good_ff == 32'hFFFF_FFFF) ? good_ff : good_ff + 32'd1;
   assign drop_inc  = (drop_ff == 32'hFFFF_FFFF) ? drop_ff : drop_ff + 32'd1;
   assign ticks_inc = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      led_in      = led_ff;
      lane_in     = lane_ff;
      parity_in   = parity_ff;
      ticks_in    = ticks_ff;
      bank_in     = bank_ff;
      have_in     = have_ff;
      good_in     = good_ff;
      drop_in     = drop_ff;
      event_res   = sfpr_pkg::EV_NONE;
      ram_wr_lane = 3'b000;
      ram_rd_en   = 1'b0;
      pixel_hit   = 1'b0;
      if (item_accept) begin
         case (opcode)
            sfpr_pkg::OP_BYTE: begin
               case (phase_ff)
                  sfpr_pkg::PH_SYNC1: begin
                     if (rx_byte == sync1_ff) begin
                        phase_in = sfpr_pkg::PH_SYNC2;
                     end
                  end
                  sfpr_pkg::PH_SYNC2: begin
                     if (rx_byte == sync2_ff) begin
                        phase_in  = sfpr_pkg::PH_READ;
                        led_in    = '0;
                        lane_in   = 2'd0;
                        parity_in = 8'd0;
                        ticks_in  = 16'd0;
                     end else if (rx_byte != sync1_ff) begin
                        phase_in = sfpr_pkg::PH_SYNC1;
                     end
                  end
                  sfpr_pkg::PH_READ: begin
                     // Byte position is tracked as pixel plus lane, so the payload
                     // length check is a compare against the pixel count.
                     if (led_wide < eff_leds) begin
                        ram_wr_lane = 3'b001 << lane_ff;
                        parity_in   = parity_ff ^ rx_byte;
                        if (lane_ff == sfpr_pkg::LANE_LAST) begin
                           lane_in = 2'd0;
                           led_in  = led_ff + LED_W'(1);
                        end else begin
                           lane_in = lane_ff + 2'd1;
                        end
                     end else begin
                        phase_in = sfpr_pkg::PH_SYNC1;
                        if (parity_ff == rx_byte) begin
                           bank_in   = ~bank_ff;
                           have_in   = 1'b1;
                           good_in   = good_inc;
                           event_res = sfpr_pkg::EV_GOOD;
                        end else begin
                           drop_in   = drop_inc;
                           event_res = sfpr_pkg::EV_CHECKSUM;
                        end
                     end
                  end
                  default: begin
                     phase_in = sfpr_pkg::PH_SYNC1;
                  end
               endcase
            end
            sfpr_pkg::OP_TICK: begin
               if (phase_ff == sfpr_pkg::PH_READ) begin
                  ticks_in = ticks_inc;
                  if (ticks_inc > timeout_ff) begin
                     phase_in  = sfpr_pkg::PH_SYNC1;
                     drop_in   = drop_inc;
                     event_res = sfpr_pkg::EV_TIMEOUT;
                  end
               end
            end
            sfpr_pkg::OP_READ: begin
               ram_rd_en = 1'b1;
               pixel_hit = have_ff && (pix_wide < eff_leds);
            end
            default: begin
            end
         endcase
      end
   end

   assign ram_wr_addr = {~bank_ff, led_ff[AW-1:0]};
   assign ram_wr_data = rx_byte;
   assign ram_rd_addr = {bank_ff, pix_wide[AW-1:0]};

   assign meta.event_res      = event_res;
   assign meta.good_frames    = good_in;
   assign meta.dropped_frames = drop_in;
   assign meta.receiver_phase = phase_in;
   assign meta.pixel_hit      = pixel_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= sfpr_pkg::RST_LED_COUNT;
         timeout_ff   <= sfpr_pkg::RST_TIMEOUT;
         sync1_ff     <= sfpr_pkg::RST_SYNC1;
         sync2_ff     <= sfpr_pkg::RST_SYNC2;
      end else if (csr_we) begin
         case (csr_index)
            sfpr_pkg::REG_LED_COUNT: led_count_ff <= csr_wdata[9:0];
            sfpr_pkg::REG_TIMEOUT:   timeout_ff   <= csr_wdata;
            sfpr_pkg::REG_SYNC1:     sync1_ff     <= csr_wdata[7:0];
            sfpr_pkg::REG_SYNC2:     sync2_ff     <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sfpr_pkg::PH_SYNC1;
         led_ff    <= '0;
         lane_ff   <= 2'd0;
         parity_ff <= 8'd0;
         ticks_ff  <= 16'd0;
         bank_ff   <= 1'b0;
         have_ff   <= 1'b0;
         good_ff   <= 32'd0;
         drop_ff   <= 32'd0;
      end else begin
         phase_ff  <= phase_in;
         led_ff    <= led_in;
         lane_ff   <= lane_in;
         parity_ff <= parity_in;
         ticks_ff  <= ticks_in;
         bank_ff   <= bank_in;
         have_ff   <= have_in;
         good_ff   <= good_in;
         drop_ff   <= drop_in;
      end
   end

   `SFPR_ASSERT_NOW(a_write_only_reading, ram_wr_lane != 3'b000, phase_ff == sfpr_pkg::PH_READ, "store written outside a frame")
   `SFPR_ASSERT_NOW(a_one_lane, 1'b1, $onehot0(ram_wr_lane), "more than one colour lane written")
   `SFPR_ASSERT_NEXT(a_bank_flip_good, item_accept && event_res == sfpr_pkg::EV_GOOD, bank_ff != $past(bank_ff) && have_ff, "good frame did not swap banks")

endmodule

`default_nettype wire

// ===== rtl/sfpr_outq.sv =====
// Result stage and two-entry output queue; also derives the input ready.
// Uses sfpr_pkg and the defines header.
`default_nettype none
`include "sync_framed_pixel_receiver_defines.svh"

module sfpr_outq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_accept,
   input  sfpr_pkg::meta_type      meta,
   input  wire logic [7:0]         ram_red,
   input  wire logic [7:0]         ram_green,
   input  wire logic [7:0]         ram_blue,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output sfpr_pkg::result_type    rsp_item
);

   logic                 p_valid_ff;
   sfpr_pkg::meta_type   p_meta_ff;
   sfpr_pkg::result_type entry_ff [2];
   sfpr_pkg::result_type push_item;
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [1:0]           count_ff, count_in;
   logic [1:0]           occupancy;
   logic                 pop;

   // The RAM read data is valid in the cycle after acceptance, alongside p_meta_ff.
   always_comb begin
      push_item.event_res      = p_meta_ff.event_res;
      push_item.red            = p_meta_ff.pixel_hit ? ram_red : 8'd0;
      push_item.green          = p_meta_ff.pixel_hit ? ram_green : 8'd0;
      push_item.blue           = p_meta_ff.pixel_hit ? ram_blue : 8'd0;
      push_item.good_frames    = p_meta_ff.good_frames;
      push_item.dropped_frames = p_meta_ff.dropped_frames;
      push_item.receiver_phase = p_meta_ff.receiver_phase;
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign occupancy = count_ff + {1'b0, p_valid_ff};
   // Items in flight never exceed the two queue entries.
   assign req_ready = (occupancy < 2'd2) || pop;

   always_comb begin
      count_in = count_ff;
      if (p_valid_ff && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!p_valid_ff && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         p_valid_ff <= item_accept;
         count_ff   <= count_in;
         if (p_valid_ff) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_accept) begin
         p_meta_ff <= meta;
      end
      if (p_valid_ff) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `SFPR_ASSERT_NOW(a_occupancy, 1'b1, occupancy <= 2'd2, "output queue overrun")
   `SFPR_ASSERT_NOW(a_ready_full, !req_ready, occupancy == 2'd2 && !pop, "ready low with room left")
   `SFPR_ASSERT_NEXT(a_push_shows, p_valid_ff && !pop, rsp_valid, "pushed item not visible")

endmodule

`default_nettype wire

// ===== rtl/sync_framed_pixel_receiver.sv =====
// Top level of the sync-framed pixel receiver.
// Uses sfpr_pkg, sfpr_ctrl, sfpr_ram (three colour lanes) and sfpr_outq.
`default_nettype none

// The receiver takes one item per clock: a serial byte, a timer tick or a
// pixel read. Bytes are framed as a first and a second sync byte, three colour
// bytes per pixel and one XOR checksum byte. Colour bytes go into the back bank
// of a two-bank pixel store that is held in three RAMs, one per colour byte,
// each addressed by bank and pixel number; a read fetches all three bytes of
// a pixel from the shown bank in one access. A matching checksum swaps the
// banks and counts a good frame; a bad checksum, or more ticks than the
// timeout while a frame is being read, drops the frame and counts it. Every
// item gives exactly one result item carrying the event, the colour bytes of
// a read (zero for other items, for reads before the first good frame and for
// indexes at or beyond the current pixel count), both saturating frame
// counters and the receiver phase after the item. The sustained rate is one
// item per cycle while the output queue has room; each result is formed from
// the registered RAM read port and the registered result stage, which feeds
// a two-entry output queue, so input acceptance continues while a result
// waits to be taken. A write and a later read of the same store entry
// are always in different cycles, and the bank only flips on a checksum byte,
// so no forwarding is needed. The store has no reset and needs no clearing
// pass after reset. Configuration registers are written through the csr port
// and should only change while the block is idle.
module sync_framed_pixel_receiver #(
   parameter int MAX_LEDS = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [8:0]  req_pixel_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [1:0]  rsp_event_res,
   output logic      [7:0]  rsp_red,
   output logic      [7:0]  rsp_green,
   output logic      [7:0]  rsp_blue,
   output logic      [31:0] rsp_good_frames,
   output logic      [31:0] rsp_dropped_frames,
   output logic      [1:0]  rsp_receiver_phase,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // Pixel address bits; the RAM adds one more bit for the bank.
   localparam int AW        = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int RAM_DEPTH = 2 << AW;

   logic                 item_accept;
   logic [2:0]           ram_wr_lane;
   logic [AW:0]          ram_wr_addr;
   logic [7:0]           ram_wr_data;
   logic                 ram_rd_en;
   logic [AW:0]          ram_rd_addr;
   logic [7:0]           ram_data [3];
   sfpr_pkg::meta_type   meta;
   sfpr_pkg::result_type rsp_item;

   assign item_accept = req_valid && req_ready;

   sfpr_ctrl #(
      .MAX_LEDS(MAX_LEDS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_accept (item_accept),
      .opcode      (req_opcode),
      .rx_byte     (req_rx_byte),
      .pixel_index (req_pixel_index),
      .ram_wr_lane (ram_wr_lane),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .meta        (meta)
   );

   // Lane 0 holds red, lane 1 green, lane 2 blue.
   for (genvar lane = 0; lane < 3; lane++) begin : g_lane
      sfpr_ram #(
         .WIDTH(8),
         .DEPTH(RAM_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_wr_lane[lane]),
         .wr_addr (ram_wr_addr),
         .wr_data (ram_wr_data),
         .rd_en   (ram_rd_en),
         .rd_addr (ram_rd_addr),
         .rd_data (ram_data[lane])
      );
   end

   sfpr_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .meta        (meta),
      .ram_red     (ram_data[0]),
      .ram_green   (ram_data[1]),
      .ram_blue    (ram_data[2]),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

   assign rsp_event_res      = rsp_item.event_res;
   assign rsp_red            = rsp_item.red;
   assign rsp_green          = rsp_item.green;
   assign rsp_blue           = rsp_item.blue;
   assign rsp_good_frames    = rsp_item.good_frames;
   assign rsp_dropped_frames = rsp_item.dropped_frames;
   assign rsp_receiver_phase = rsp_item.receiver_phase;

endmodule

`default_nettype wire
